### rtl/text_stream_cat_filter_assert.svh
// Assertion macros for the text stream cat filter
`ifndef TEXT_STREAM_CAT_FILTER_ASSERT_SVH
`define TEXT_STREAM_CAT_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define TSCF_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("tscf: assertion failed");
`define TSCF_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("tscf: assertion failed");
`else
`define TSCF_ASSERT(label, prop)
`define TSCF_ASSERT_NEXT(label, cond, prop)
`endif
`endif

### rtl/tscf_pkg.sv
// Package: constants, register indexes and shared types of the text stream cat filter
package tscf_pkg;

   localparam int NUMBER_DIGITS    = 7;
   localparam int NUMBER_PAD_WIDTH = 6;
   localparam int MAX_RESULTS      = 10;

   localparam int NUM_W = 4 * NUMBER_DIGITS;
   localparam int SIG_W = $clog2(NUMBER_DIGITS + 1);
   localparam int POS_W = $clog2(NUMBER_PAD_WIDTH + NUMBER_DIGITS + 4);

   localparam int JQ_DEPTH = 2;
   localparam int OQ_DEPTH = 2;

   localparam logic [7:0] CHAR_TAB     = 8'd9;
   localparam logic [7:0] CHAR_LF      = 8'd10;
   localparam logic [7:0] CHAR_SPACE   = 8'd32;
   localparam logic [7:0] CHAR_DOLLAR  = 8'd36;
   localparam logic [7:0] CHAR_ZERO    = 8'd48;
   localparam logic [7:0] CHAR_QMARK   = 8'd63;
   localparam logic [7:0] CHAR_I       = 8'd73;
   localparam logic [7:0] CHAR_CARET   = 8'd94;
   localparam logic [7:0] CHAR_DEL     = 8'd127;
   localparam logic [7:0] CTRL_LIMIT   = 8'd32;
   localparam logic [7:0] CARET_OFFSET = 8'd64;

   localparam logic [1:0] NL_RUN_NONE    = 2'd0;
   localparam logic [1:0] NL_RUN_START   = 2'd1;
   localparam logic [1:0] NL_RUN_SQUEEZE = 2'd3;

   typedef enum logic [2:0] {
      REG_SQUEEZE_BLANK     = 3'd0,
      REG_NUMBER_EVERY_LINE = 3'd1,
      REG_NUMBER_NONBLANK   = 3'd2,
      REG_SHOW_LINE_END     = 3'd3,
      REG_SHOW_TAB          = 3'd4,
      REG_SHOW_CONTROL      = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic squeeze_blank;
      logic number_every_line;
      logic number_nonblank;
      logic show_line_end;
      logic show_tab;
      logic show_control;
   } cfg_type;

   typedef struct packed {
      logic             numbered;
      logic [NUM_W-1:0] digits;
      logic [SIG_W-1:0] sig;
      logic             blank_pad;
      logic [1:0]       body_len;
      logic [7:0]       body0;
      logic [7:0]       body1;
   } job_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_entry_type;

endpackage

### rtl/tscf_front.sv
// Front end: stream state, line numbering and classification of each byte into a job
module tscf_front (
   input  logic             clock,
   input  logic             reset,
   input  tscf_pkg::cfg_type cfg,
   input  logic             accept,
   input  logic [7:0]       in_byte,
   input  logic             first_of_file,
   output logic             job_push,
   output tscf_pkg::job_type job
);
   import tscf_pkg::*;

   logic [NUM_W-1:0] line_number_ff, line_number_in;
   logic             at_line_start_ff, at_line_start_in;
   logic [1:0]       newline_run_ff, newline_run_in;
   logic             line_has_text_ff, line_has_text_in;

   logic [NUM_W-1:0] ln, ln_bumped;
   logic             als, als_new, lht;
   logic [1:0]       nr, nr_new;
   logic             nl, squelch, empty, num, all_nines, carry, is_ctrl;
   logic [SIG_W-1:0] sig;
   logic [3:0]       d;

   always_comb begin
      ln  = first_of_file ? NUM_W'(1) : line_number_ff;
      als = first_of_file ? 1'b1 : at_line_start_ff;
      nr  = first_of_file ? NL_RUN_START : newline_run_ff;
      lht = first_of_file ? 1'b0 : line_has_text_ff;

      nl = (in_byte == CHAR_LF);
      if (nl) begin
         nr_new = (nr == NL_RUN_SQUEEZE) ? NL_RUN_SQUEEZE : nr + 2'd1;
      end else begin
         nr_new = NL_RUN_NONE;
      end
      squelch = cfg.squeeze_blank && (nr_new == NL_RUN_SQUEEZE);
      empty   = nl && !lht;

      num     = 1'b0;
      als_new = als;
      if (cfg.number_nonblank) begin
         if (als && !nl) begin
            num     = 1'b1;
            als_new = 1'b0;
         end else if (nl) begin
            als_new = 1'b1;
         end
      end else if (cfg.number_every_line) begin
         num = als && !squelch;
         if (nl) begin
            als_new = 1'b1;
         end else if (num) begin
            als_new = 1'b0;
         end
      end else begin
         als_new = nl;
      end

      sig       = SIG_W'(1);
      all_nines = 1'b1;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
         if (ln[4*i +: 4] != 4'd0) sig = SIG_W'(i + 1);
         if (ln[4*i +: 4] != 4'd9) all_nines = 1'b0;
      end

      ln_bumped = ln;
      carry     = 1'b1;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
         d = ln[4*i +: 4];
         if (carry) begin
            if (d == 4'd9) begin
               ln_bumped[4*i +: 4] = 4'd0;
            end else begin
               ln_bumped[4*i +: 4] = d + 4'd1;
               carry = 1'b0;
            end
         end
      end
      if (all_nines) ln_bumped = ln;

      is_ctrl = ((in_byte < CTRL_LIMIT) && (in_byte != CHAR_TAB) && !nl) ||
                (in_byte == CHAR_DEL);

      job.numbered  = num;
      job.digits    = ln;
      job.sig       = sig;
      job.blank_pad = 1'b0;
      job.body_len  = 2'd1;
      job.body0     = in_byte;
      job.body1     = in_byte;
      if (nl && cfg.show_line_end) begin
         job.blank_pad = cfg.number_nonblank && empty;
         job.body_len  = 2'd2;
         job.body0     = CHAR_DOLLAR;
         job.body1     = CHAR_LF;
      end else if ((in_byte == CHAR_TAB) && cfg.show_tab) begin
         job.body_len = 2'd2;
         job.body0    = CHAR_CARET;
         job.body1    = CHAR_I;
      end else if (cfg.show_control && is_ctrl) begin
         job.body_len = 2'd2;
         job.body0    = CHAR_CARET;
         job.body1    = (in_byte == CHAR_DEL) ? CHAR_QMARK : in_byte + CARET_OFFSET;
      end

      job_push = accept && !squelch;

      line_number_in   = line_number_ff;
      at_line_start_in = at_line_start_ff;
      newline_run_in   = newline_run_ff;
      line_has_text_in = line_has_text_ff;
      if (accept) begin
         line_number_in   = num ? ln_bumped : ln;
         at_line_start_in = als_new;
         newline_run_in   = nr_new;
         line_has_text_in = !nl;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_number_ff   <= NUM_W'(1);
         at_line_start_ff <= 1'b1;
         newline_run_ff   <= NL_RUN_START;
         line_has_text_ff <= 1'b0;
      end else begin
         line_number_ff   <= line_number_in;
         at_line_start_ff <= at_line_start_in;
         newline_run_ff   <= newline_run_in;
         line_has_text_ff <= line_has_text_in;
      end
   end

endmodule

### rtl/tscf_job_queue.sv
// Job queue between front end and back end
`include "text_stream_cat_filter_assert.svh"
module tscf_job_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tscf_pkg::job_type push_job,
   input  logic              pop,
   output logic              head_valid,
   output tscf_pkg::job_type head_job,
   output logic              full
);
   import tscf_pkg::*;

   localparam int PTR_W = (JQ_DEPTH > 1) ? $clog2(JQ_DEPTH) : 1;
   localparam int CNT_W = $clog2(JQ_DEPTH + 1);

   job_type            mem_ff [JQ_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      head_valid = (count_ff != '0);
      head_job   = mem_ff[rd_ptr_ff];
      full       = (count_ff == CNT_W'(JQ_DEPTH));

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(JQ_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(JQ_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `TSCF_ASSERT(a_jq_no_overflow, (count_ff == CNT_W'(JQ_DEPTH)) |-> !push)
   `TSCF_ASSERT(a_jq_no_underflow, (count_ff == '0) |-> !pop)
   `TSCF_ASSERT_NEXT(a_jq_fill, push && !pop && (count_ff == '0), head_valid)

endmodule

### rtl/tscf_back.sv
// Back end: expands each job into output bytes and holds them in the result queue
`include "text_stream_cat_filter_assert.svh"
module tscf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  tscf_pkg::job_type job,
   output logic              job_pop,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_last
);
   import tscf_pkg::*;

   localparam int PTR_W = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;
   localparam int CNT_W = $clog2(OQ_DEPTH + 1);
   localparam logic [POS_W-1:0] PAD_POS = POS_W'(NUMBER_PAD_WIDTH);
   localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_RESULTS);

   logic [POS_W-1:0]   pos_ff, pos_in;
   rsp_entry_type      oq_ff [OQ_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   logic [POS_W-1:0]   sig_pos, spaces, prefix_len, total, total_cap, didx, q;
   logic [3:0]         digit;
   logic               emit, emit_last, oq_pop;
   rsp_entry_type      entry;

   always_comb begin
      sig_pos = POS_W'(job.sig);
      spaces  = (PAD_POS > sig_pos) ? PAD_POS - sig_pos : '0;
      if (job.numbered) begin
         prefix_len = spaces + sig_pos + POS_W'(1);
      end else if (job.blank_pad) begin
         prefix_len = PAD_POS + POS_W'(1);
      end else begin
         prefix_len = '0;
      end
      total     = prefix_len + POS_W'(job.body_len);
      total_cap = (total > MAX_POS) ? MAX_POS : total;

      didx  = sig_pos - POS_W'(1) - (pos_ff - spaces);
      digit = 4'd0;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
         if (didx == POS_W'(i)) digit = job.digits[4*i +: 4];
      end
      q = pos_ff - prefix_len;

      if (pos_ff < prefix_len) begin
         if (job.numbered) begin
            if (pos_ff < spaces) begin
               entry.out_byte = CHAR_SPACE;
            end else if (pos_ff < spaces + sig_pos) begin
               entry.out_byte = CHAR_ZERO + {4'd0, digit};
            end else begin
               entry.out_byte = CHAR_TAB;
            end
         end else begin
            entry.out_byte = (pos_ff < PAD_POS) ? CHAR_SPACE : CHAR_TAB;
         end
      end else begin
         entry.out_byte = (q == '0) ? job.body0 : job.body1;
      end

      emit_last  = (pos_ff == total_cap - POS_W'(1));
      entry.last = emit_last;
      emit       = job_valid && (count_ff < CNT_W'(OQ_DEPTH));
      job_pop    = emit && emit_last;

      pos_in = pos_ff;
      if (emit) begin
         pos_in = emit_last ? '0 : pos_ff + POS_W'(1);
      end

      rsp_empty    = (count_ff == '0);
      rsp_out_byte = oq_ff[rd_ptr_ff].out_byte;
      rsp_last     = oq_ff[rd_ptr_ff].last;
      oq_pop       = rsp_pop && !rsp_empty;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (emit) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(OQ_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (oq_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(OQ_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({emit, oq_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         oq_ff[wr_ptr_ff] <= entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         pos_ff    <= pos_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `TSCF_ASSERT(a_pos_in_range, job_valid |-> (pos_ff < total_cap))
   `TSCF_ASSERT_NEXT(a_pos_wrap, job_pop, pos_ff == '0)

endmodule

### rtl/text_stream_cat_filter.sv
// Top level: configuration registers and the front end, job queue and back end of the cat filter
//
// channel  direction  transaction accepted when    fields
// req      in         req_push  && !req_full       req_in_byte, req_first_of_file
// rsp      out        rsp_pop   && !rsp_empty      rsp_out_byte, rsp_last
// csr      in         csr_we                       csr_index, csr_wdata
//
// The back end writes one output byte per cycle while the result queue has room; an
// input byte yields 1 to 10 output bytes, and a squeezed blank line yields nothing.
// A request passes through the job queue and then the result queue on its way to rsp.
// req_full rises while the two-entry job queue is full; the back end stalls while
// the two-entry result queue is full. Reset is synchronous and clears all state but the queue storage.
module text_stream_cat_filter (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_byte,
   input  logic       req_first_of_file,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last,
   input  logic       csr_we,
   input  logic [2:0] csr_index,
   input  logic       csr_wdata
);
   import tscf_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    accept, job_push, head_valid, job_pop;
   job_type job, head_job;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_SQUEEZE_BLANK:     cfg_in.squeeze_blank     = csr_wdata;
            REG_NUMBER_EVERY_LINE: cfg_in.number_every_line = csr_wdata;
            REG_NUMBER_NONBLANK:   cfg_in.number_nonblank   = csr_wdata;
            REG_SHOW_LINE_END:     cfg_in.show_line_end     = csr_wdata;
            REG_SHOW_TAB:          cfg_in.show_tab          = csr_wdata;
            REG_SHOW_CONTROL:      cfg_in.show_control      = csr_wdata;
            default:               cfg_in = cfg_ff;
         endcase
      end
      accept = req_push && !req_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tscf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .accept        (accept),
      .in_byte       (req_in_byte),
      .first_of_file (req_first_of_file),
      .job_push      (job_push),
      .job           (job)
   );

   tscf_job_queue u_job_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (job),
      .pop        (job_pop),
      .head_valid (head_valid),
      .head_job   (head_job),
      .full       (req_full)
   );

   tscf_back u_back (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (head_valid),
      .job          (head_job),
      .job_pop      (job_pop),
      .rsp_pop      (rsp_pop),
      .rsp_empty    (rsp_empty),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

### test/tb_text_stream_cat_filter.sv
`timescale 1ns / 1ps
// Testbench for text_stream_cat_filter: directed table plus random text lines, checked by a byte predictor
module tb_text_stream_cat_filter;
   import tscf_pkg::*;

   localparam int SETTLE_CYCLES = 16;
   localparam int PRESSURE_HOLD = 200;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 30;
   localparam int REPORT_LIMIT  = 40;
   localparam longint LIMIT_NS  = 64'd5_000_000;

   localparam logic [2:0] REG_SPARE_LO = 3'd6;
   localparam logic [2:0] REG_SPARE_HI = 3'd7;

   // bit order: squeeze, every line, nonblank, line end, tab, control
   localparam cfg_type CFG_PLAIN        = cfg_type'(6'b000000);
   localparam cfg_type CFG_SHOW_ALL     = cfg_type'(6'b000111);
   localparam cfg_type CFG_SQUEEZE_NUM  = cfg_type'(6'b110000);
   localparam cfg_type CFG_NONBLANK_END = cfg_type'(6'b011100);
   localparam cfg_type CFG_NONBLANK     = cfg_type'(6'b001000);
   localparam cfg_type CFG_NUMBER_ALL   = cfg_type'(6'b010000);

   typedef struct packed {
      cfg_type    cfg;
      logic [7:0] data;
      logic       fof;
      logic       typed;
      logic [7:0] result;
   } dir_row_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_push;
   logic       req_full;
   logic [7:0] req_in_byte;
   logic       req_first_of_file;
   logic       rsp_empty;
   logic       rsp_pop;
   logic [7:0] rsp_out_byte;
   logic       rsp_last;
   logic       csr_we;
   logic [2:0] csr_index;
   logic       csr_wdata;

   text_stream_cat_filter dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_in_byte       (req_in_byte),
      .req_first_of_file (req_first_of_file),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last          (rsp_last),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   cfg_type          cfg_model;
   logic [NUM_W-1:0] line_bcd;
   logic             at_start;
   logic             has_text;
   logic [1:0]       nl_run;
   logic [7:0]       out_run [MAX_RESULTS];
   int               out_len;

   rsp_entry_type expected_out [$];
   dir_row_type   dir_rows [$];

   int errors          = 0;
   int items_sent      = 0;
   int bytes_checked   = 0;
   int settings_used   = 0;
   int stall_requests  = 0;
   bit sender_burst    = 1'b0;
   bit rsp_burst       = 1'b0;
   bit spare_toggle    = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #(LIMIT_NS);
      $display("timeout with %0d bytes still expected", expected_out.size());
      $display("tb_text_stream_cat_filter: FAIL");
      $finish;
   end

   task flag_error(input string msg);
      errors++;
      if (errors <= REPORT_LIMIT) $display("%0t mismatch: %s", $time, msg);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function void restart_count();
      line_bcd = NUM_W'(1);
      at_start = 1'b1;
      nl_run   = NL_RUN_START;
      has_text = 1'b0;
   endfunction

   function void put_out(input logic [7:0] v);
      if (out_len < MAX_RESULTS) begin
         out_run[out_len] = v;
         out_len++;
      end
   endfunction

   function void put_line_number();
      int sig;
      bit nines;
      bit done;
      sig   = 1;
      nines = 1'b1;
      done  = 1'b0;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
         if (line_bcd[4*i +: 4] != 4'd0) sig = i + 1;
         if (line_bcd[4*i +: 4] != 4'd9) nines = 1'b0;
      end
      for (int i = sig; i < NUMBER_PAD_WIDTH; i++) put_out(CHAR_SPACE);
      for (int i = sig - 1; i >= 0; i--) put_out(CHAR_ZERO + 8'(line_bcd[4*i +: 4]));
      put_out(CHAR_TAB);
      if (!nines) begin
         for (int i = 0; i < NUMBER_DIGITS; i++) begin
            if (!done) begin
               if (line_bcd[4*i +: 4] == 4'd9) begin
                  line_bcd[4*i +: 4] = 4'd0;
               end else begin
                  line_bcd[4*i +: 4] = line_bcd[4*i +: 4] + 4'd1;
                  done = 1'b1;
               end
            end
         end
      end
   endfunction

   function void filter_byte(input logic [7:0] b, input logic fof);
      logic nl;
      logic squelch;
      logic empty;
      out_len = 0;
      if (fof) restart_count();
      nl = (b == CHAR_LF);
      if (nl) nl_run = (nl_run < NL_RUN_SQUEEZE) ? nl_run + 2'd1 : NL_RUN_SQUEEZE;
      else nl_run = NL_RUN_NONE;
      squelch  = cfg_model.squeeze_blank && (nl_run == NL_RUN_SQUEEZE);
      empty    = nl && !has_text;
      has_text = !nl;
      if (cfg_model.number_nonblank) begin
         if (at_start && !nl) begin
            put_line_number();
            at_start = 1'b0;
         end else if (nl) begin
            at_start = 1'b1;
         end
      end else if (cfg_model.number_every_line) begin
         if (at_start && !squelch) begin
            put_line_number();
            at_start = 1'b0;
         end
         if (nl) at_start = 1'b1;
      end else begin
         at_start = nl;
      end
      if (squelch) begin
         out_len = 0;
      end else if (nl && cfg_model.show_line_end) begin
         if (cfg_model.number_nonblank && empty) begin
            for (int i = 0; i < NUMBER_PAD_WIDTH; i++) put_out(CHAR_SPACE);
            put_out(CHAR_TAB);
         end
         put_out(CHAR_DOLLAR);
         put_out(CHAR_LF);
      end else if (b == CHAR_TAB && cfg_model.show_tab) begin
         put_out(CHAR_CARET);
         put_out(CHAR_I);
      end else if (cfg_model.show_control &&
                   ((b < CTRL_LIMIT && b != CHAR_TAB && b != CHAR_LF) || b == CHAR_DEL)) begin
         put_out(CHAR_CARET);
         put_out(b == CHAR_DEL ? CHAR_QMARK : b + CARET_OFFSET);
      end else begin
         put_out(b);
      end
   endfunction

   function automatic logic [7:0] text_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 8'($urandom_range(32, 126));
      if (r < 78) return CHAR_TAB;
      if (r < 86) return 8'($urandom_range(0, 31));
      if (r < 90) return CHAR_DEL;
      return 8'($urandom_range(128, 255));
   endfunction

   task add_row(input cfg_type c, input logic [7:0] d, input logic f,
                input logic t, input logic [7:0] res);
      dir_rows.push_back(dir_row_type'({c, d, f, t, res}));
   endtask

   task put_reg(input logic [2:0] idx, input logic v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      case (idx)
         REG_SQUEEZE_BLANK:     cfg_model.squeeze_blank     = v;
         REG_NUMBER_EVERY_LINE: cfg_model.number_every_line = v;
         REG_NUMBER_NONBLANK:   cfg_model.number_nonblank   = v;
         REG_SHOW_LINE_END:     cfg_model.show_line_end     = v;
         REG_SHOW_TAB:          cfg_model.show_tab          = v;
         REG_SHOW_CONTROL:      cfg_model.show_control      = v;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task write_cfg(input cfg_type c);
      put_reg(REG_SQUEEZE_BLANK, c.squeeze_blank);
      put_reg(REG_NUMBER_EVERY_LINE, c.number_every_line);
      put_reg(REG_NUMBER_NONBLANK, c.number_nonblank);
      put_reg(REG_SHOW_LINE_END, c.show_line_end);
      put_reg(REG_SHOW_TAB, c.show_tab);
      put_reg(REG_SHOW_CONTROL, c.show_control);
      put_reg(spare_toggle ? REG_SPARE_HI : REG_SPARE_LO, 1'($urandom));
      spare_toggle = !spare_toggle;
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task wait_idle();
      req_push <= 1'b0;
      while (expected_out.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task send_item(input logic [7:0] b, input logic fof, input logic typed,
                  input logic [7:0] res);
      int gap;
      gap = sender_burst ? 0 : pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push          <= 1'b1;
      req_in_byte       <= b;
      req_first_of_file <= fof;
      @(posedge clock);
      while (req_full) @(posedge clock);
      filter_byte(b, fof);
      if (typed) begin
         expected_out.push_back(rsp_entry_type'({res, 1'b1}));
      end else begin
         for (int j = 0; j < out_len; j++)
            expected_out.push_back(rsp_entry_type'({out_run[j], j == out_len - 1}));
      end
      items_sent++;
      @(negedge clock);
   endtask

   task send_text(input int count);
      int sent;
      int len;
      int lfs;
      logic fof_next;
      sent     = 0;
      fof_next = 1'($urandom);
      while (sent < count) begin
         if ($urandom_range(0, 99) < 8) begin
            send_item(8'($urandom), 1'($urandom), 1'b0, 8'd0);
            sent++;
         end else begin
            len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            lfs = ($urandom_range(0, 5) == 0) ? $urandom_range(2, 4) : 1;
            for (int k = 0; k < len; k++) begin
               send_item(text_char(), fof_next, 1'b0, 8'd0);
               fof_next = 1'b0;
               sent++;
            end
            for (int k = 0; k < lfs; k++) begin
               send_item(CHAR_LF, fof_next, 1'b0, 8'd0);
               fof_next = 1'b0;
               sent++;
            end
            if ($urandom_range(0, 6) == 0) fof_next = 1'b1;
         end
      end
   endtask

   initial begin
      int hold;
      int served;
      hold    = 0;
      served  = 0;
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_requests != served) begin
            served = stall_requests;
            hold   = PRESSURE_HOLD;
         end
         if (hold > 0) begin
            rsp_pop <= 1'b0;
            hold--;
         end else begin
            rsp_pop <= 1'b1;
            if (!rsp_burst) hold = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      rsp_entry_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_out.size() == 0) begin
            flag_error($sformatf("unexpected byte %h last %b", rsp_out_byte, rsp_last));
         end else begin
            want = expected_out.pop_front();
            bytes_checked++;
            if (rsp_out_byte !== want.out_byte)
               flag_error($sformatf("out_byte %h, expected %h", rsp_out_byte, want.out_byte));
            if (rsp_last !== want.last)
               flag_error($sformatf("last %b, expected %b (byte %h)", rsp_last, want.last,
                                    want.out_byte));
         end
      end
   end

   initial begin
      cfg_type phase_cfg;
      reset             = 1'b1;
      req_push          = 1'b0;
      req_in_byte       = 8'd0;
      req_first_of_file = 1'b0;
      csr_we            = 1'b0;
      csr_index         = REG_SQUEEZE_BLANK;
      csr_wdata         = 1'b0;
      cfg_model         = CFG_PLAIN;
      restart_count();

      add_row(CFG_PLAIN, "A", 1'b1, 1'b1, "A");
      add_row(CFG_PLAIN, 8'hFF, 1'b0, 1'b1, 8'hFF);
      add_row(CFG_PLAIN, 8'h00, 1'b0, 1'b1, 8'h00);
      add_row(CFG_PLAIN, CHAR_DEL, 1'b0, 1'b1, CHAR_DEL);
      add_row(CFG_PLAIN, CHAR_TAB, 1'b0, 1'b1, CHAR_TAB);
      add_row(CFG_PLAIN, CHAR_LF, 1'b0, 1'b1, CHAR_LF);
      add_row(CFG_SHOW_ALL, CHAR_TAB, 1'b0, 1'b0, 8'd0);
      add_row(CFG_SHOW_ALL, 8'h00, 1'b0, 1'b0, 8'd0);
      add_row(CFG_SHOW_ALL, CHAR_DEL, 1'b0, 1'b0, 8'd0);
      add_row(CFG_SHOW_ALL, 8'hFF, 1'b0, 1'b1, 8'hFF);
      add_row(CFG_SHOW_ALL, CHAR_LF, 1'b0, 1'b0, 8'd0);
      add_row(CFG_SQUEEZE_NUM, "x", 1'b1, 1'b0, 8'd0);
      add_row(CFG_SQUEEZE_NUM, CHAR_LF, 1'b0, 1'b0, 8'd0);
      add_row(CFG_SQUEEZE_NUM, CHAR_LF, 1'b0, 1'b0, 8'd0);
      add_row(CFG_SQUEEZE_NUM, CHAR_LF, 1'b0, 1'b0, 8'd0);
      add_row(CFG_SQUEEZE_NUM, "y", 1'b0, 1'b0, 8'd0);
      add_row(CFG_NONBLANK_END, "z", 1'b1, 1'b0, 8'd0);
      add_row(CFG_NONBLANK_END, CHAR_LF, 1'b0, 1'b0, 8'd0);
      add_row(CFG_NONBLANK_END, CHAR_LF, 1'b0, 1'b0, 8'd0);
      add_row(CFG_NONBLANK, CHAR_LF, 1'b0, 1'b1, CHAR_LF);
      add_row(CFG_NONBLANK, "q", 1'b0, 1'b0, 8'd0);
      add_row(CFG_PLAIN, "a", 1'b1, 1'b1, "a");
      add_row(CFG_NUMBER_ALL, "b", 1'b0, 1'b1, "b");
      add_row(CFG_NUMBER_ALL, CHAR_LF, 1'b0, 1'b1, CHAR_LF);
      add_row(CFG_NUMBER_ALL, "c", 1'b0, 1'b0, 8'd0);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < dir_rows.size(); i++) begin
         if (i == 0 || dir_rows[i].cfg != cfg_model) begin
            wait_idle();
            write_cfg(dir_rows[i].cfg);
         end
         send_item(dir_rows[i].data, dir_rows[i].fof, dir_rows[i].typed, dir_rows[i].result);
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 0) phase_cfg = CFG_PLAIN;
         else if (p == 1) phase_cfg = cfg_type'(6'b111111);
         else phase_cfg = cfg_type'(6'($urandom));
         wait_idle();
         write_cfg(phase_cfg);
         sender_burst = ($urandom_range(0, 3) == 0);
         rsp_burst    = ($urandom_range(0, 3) == 0);
         if (p == 3) begin
            sender_burst = 1'b1;
            rsp_burst    = 1'b0;
            stall_requests++;
         end
         send_text(PHASE_ITEMS);
      end

      wait_idle();
      $display("covered %0d input bytes over %0d register settings, %0d output bytes checked",
               items_sent, settings_used, bytes_checked);
      $display("included squeezed blank lines, numbering modes, caret forms and a full stall");
      if (errors == 0 && expected_out.size() == 0) begin
         $display("tb_text_stream_cat_filter: PASS");
      end else begin
         $display("tb_text_stream_cat_filter: FAIL");
      end
      $finish;
   end

endmodule
